// ----- hdl/pgd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgd_pkg
// shared types and constants of the peak ground displacement tracker
// ----------------------------------------------------------------------------
package pgd_pkg;

  // parameter defaults
  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int POSITION_BITS_DEF = 24;
  localparam int QUEUE_DEPTH       = 2;

  // fixed field widths
  localparam int START_W = 12;
  localparam int BOUND_W = 13;
  localparam int PEAK_W  = 25;
  localparam int IDX_W   = 12;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_LEADER = 2'd2;
  localparam logic [BOUND_W-1:0] END_RESET = 13'd4096;

  // sample classification
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_REF  = 2'd1;
  localparam logic [1:0] OP_MEAS = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       res_ok;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/pgd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgd_front
// counts samples, finds the reference and classifies each transaction
// ----------------------------------------------------------------------------
module pgd_front #(
  parameter int MAX_SAMPLES   = pgd_pkg::MAX_SAMPLES_DEF,
  parameter int POSITION_BITS = pgd_pkg::POSITION_BITS_DEF,
  parameter int CNT_W         = $clog2(MAX_SAMPLES + 1)
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [POSITION_BITS-1:0]     in_up_pos,
  input  wire  signed [POSITION_BITS-1:0]     in_north_pos,
  input  wire  signed [POSITION_BITS-1:0]     in_east_pos,
  input  wire                                 in_sample_valid,
  input  wire                                 in_last_sample,
  input  wire  [pgd_pkg::START_W-1:0]         start_index,
  input  wire  [pgd_pkg::BOUND_W-1:0]         end_index,
  input  wire  [pgd_pkg::BOUND_W-1:0]         leader_limit,
  input  wire                                 q_full,
  output logic                                q_push,
  output pgd_pkg::ctl_t                       q_ctl,
  output logic [CNT_W-1:0]                    q_idx,
  output logic [3*POSITION_BITS-1:0]          q_pos
);
  import pgd_pkg::*;

  localparam int CMP_W = (CNT_W > BOUND_W) ? CNT_W : BOUND_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] ref_pos_r, ref_pos_nxt;

  logic [CMP_W-1:0] idx_x, start_x, end_x, leader_x, pos_now_x;
  logic             in_window, ref_hit, meas_hit, found_now;
  logic [CNT_W-1:0] pos_now;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    idx_x     = CMP_W'(cnt_r);
    start_x   = CMP_W'(start_index);
    end_x     = CMP_W'(end_index);
    leader_x  = CMP_W'(leader_limit);
    in_window = (cnt_r < CNT_W'(MAX_SAMPLES)) & in_sample_valid;
    // reference: first valid sample at start, or past it while below leader limit
    ref_hit   = in_window & ~found_r & (idx_x >= start_x) &
                ((idx_x == start_x) | (idx_x < leader_x));
    meas_hit  = in_window & found_r & (idx_x < end_x);
    found_now = found_r | ref_hit;
    pos_now   = ref_hit ? cnt_r : ref_pos_r;
    pos_now_x = CMP_W'(pos_now);

    q_ctl.op     = ref_hit ? OP_REF : (meas_hit ? OP_MEAS : OP_NONE);
    q_ctl.last   = in_last_sample;
    q_ctl.res_ok = found_now & (pos_now_x < end_x);
    q_idx        = cnt_r;
    q_pos        = {in_up_pos, in_north_pos, in_east_pos};

    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    ref_pos_nxt = ref_pos_r;
    if (q_push) begin
      if (in_last_sample) begin
        cnt_nxt     = '0;
        found_nxt   = 1'b0;
        ref_pos_nxt = '0;
      end else begin
        if (cnt_r < CNT_W'(MAX_SAMPLES)) cnt_nxt = cnt_r + CNT_W'(1);
        found_nxt   = found_now;
        ref_pos_nxt = pos_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      found_r   <= 1'b0;
      ref_pos_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      found_r   <= found_nxt;
      ref_pos_r <= ref_pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pgd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgd_queue
// short command queue between the classifier and the distance engine
// ----------------------------------------------------------------------------
module pgd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = pgd_pkg::QUEUE_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [W-1:0]  wdata,
  output logic         full,
  input  wire          pop,
  output logic         nempty,
  output logic [W-1:0] rdata
);
  import pgd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign nempty = (count_r != '0);
  assign rdata  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pgd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgd_back
// squared distance over a shared multiplier, peak tracking, square root
// ----------------------------------------------------------------------------
module pgd_back #(
  parameter int POSITION_BITS = pgd_pkg::POSITION_BITS_DEF,
  parameter int CNT_W         = 13
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_nempty,
  output logic                             q_pop,
  input  pgd_pkg::ctl_t                    q_ctl,
  input  wire  [CNT_W-1:0]                 q_idx,
  input  wire  [3*POSITION_BITS-1:0]       q_pos,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_result_valid,
  output logic [pgd_pkg::PEAK_W-1:0]       out_peak_displacement,
  output logic [pgd_pkg::IDX_W-1:0]        out_reference_index,
  output logic [pgd_pkg::IDX_W-1:0]        out_peak_index
);
  import pgd_pkg::*;

  localparam int P       = POSITION_BITS;
  localparam int MAG_W   = P + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SQ_W    = 2 * P + 3;
  localparam int SQ_ITER = (SQ_W + 1) / 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAG  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] STEP_EAST = 3'd2;
  localparam logic [2:0] STEP_LAST = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       step_r;
  logic             last_r, ok_r;
  logic [CNT_W-1:0] idx_r;

  logic signed [P-1:0] cur_u_r, cur_n_r, cur_e_r;
  logic signed [P-1:0] ref_u_r, ref_n_r, ref_e_r;
  logic [CNT_W-1:0]    ref_pos_r, best_pos_r;
  logic [SQ_W-1:0]     best_r, acc_r;
  logic [MAG_W-1:0]    mag_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SQ_W-1:0]     rem_r, root_r, bit_r;

  logic                out_valid_r, out_valid_nxt, out_res_r;
  logic [PEAK_W-1:0]   out_peak_r;
  logic [IDX_W-1:0]    out_ref_r, out_pk_r;

  logic signed [P-1:0]     sel_cur, sel_ref;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [SQ_W-1:0]         trial;
  logic                    out_free;

  assign q_pop    = (state_r == S_IDLE) & q_nempty;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    case (step_r)
      3'd0: begin
        sel_cur = cur_u_r;
        sel_ref = ref_u_r;
      end
      3'd1: begin
        sel_cur = cur_n_r;
        sel_ref = ref_n_r;
      end
      default: begin
        sel_cur = cur_e_r;
        sel_ref = ref_e_r;
      end
    endcase
    diff  = MAG_W'(sel_cur) - MAG_W'(sel_ref);
    mag   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    trial = root_r + bit_r;
  end

  // output valid drops once taken and rises when a new result is loaded
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if ((state_r == S_OUT) && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_nempty) begin
            step_r <= '0;
            if (q_ctl.op == OP_MEAS) begin
              state_r <= S_MAG;
            end else if (q_ctl.last) begin
              state_r <= S_FIN;
            end
          end
        end
        S_MAG: begin
          step_r <= step_r + 3'd1;
          if (step_r == STEP_LAST) state_r <= S_CMP;
        end
        S_CMP: begin
          state_r <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_r == SQ_W'(1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_nempty) begin
          last_r  <= q_ctl.last;
          ok_r    <= q_ctl.res_ok;
          idx_r   <= q_idx;
          cur_u_r <= q_pos[3*P-1:2*P];
          cur_n_r <= q_pos[2*P-1:P];
          cur_e_r <= q_pos[P-1:0];
          acc_r   <= '0;
          if (q_ctl.op == OP_REF) begin
            ref_u_r    <= q_pos[3*P-1:2*P];
            ref_n_r    <= q_pos[2*P-1:P];
            ref_e_r    <= q_pos[P-1:0];
            ref_pos_r  <= q_idx;
            best_r     <= '0;
            best_pos_r <= q_idx;
          end
        end
      end
      S_MAG: begin
        // magnitude, square and accumulate overlap across the three channels
        if (step_r <= STEP_EAST) mag_r <= mag;
        if (step_r != 3'd0 && step_r <= 3'd3) prod_r <= mag_r * mag_r;
        if (step_r >= STEP_EAST) acc_r <= acc_r + SQ_W'(prod_r);
      end
      S_CMP: begin
        if (acc_r > best_r) begin
          best_r     <= acc_r;
          best_pos_r <= idx_r;
        end
      end
      S_FIN: begin
        rem_r  <= best_r;
        root_r <= '0;
        bit_r  <= SQ_W'(1) << (2 * (SQ_ITER - 1));
      end
      S_SQRT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_OUT: begin
        if (out_free) begin
          out_res_r  <= ok_r;
          out_peak_r <= ok_r ? PEAK_W'(root_r) : '0;
          out_ref_r  <= ok_r ? IDX_W'(ref_pos_r) : '0;
          out_pk_r   <= ok_r ? IDX_W'(best_pos_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_result_valid      = out_res_r;
  assign out_peak_displacement = out_peak_r;
  assign out_reference_index   = out_ref_r;
  assign out_peak_index        = out_pk_r;

endmodule
`default_nettype wire

// ----- hdl/peak_ground_displacement_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// peak_ground_displacement_tracker
// peak displacement from a reference over a window of three-channel samples
// ----------------------------------------------------------------------------
// throughput: a measured sample holds the back end for the three passes through
//   the shared multiplier plus the peak compare before the next one is taken
// latency: after the last sample is taken it passes the queue, the distance steps
//   when that sample is measured, the one-bit-per-cycle square root and the
//   output register
// reset: synchronous, active low; window state, queue and output valid cleared,
//   registers return to start 0, end 4096, leader limit 0
// ----------------------------------------------------------------------------
module peak_ground_displacement_tracker #(
  parameter int MAX_SAMPLES   = pgd_pkg::MAX_SAMPLES_DEF,
  parameter int POSITION_BITS = pgd_pkg::POSITION_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [POSITION_BITS-1:0]  in_up_pos,
  input  wire  signed [POSITION_BITS-1:0]  in_north_pos,
  input  wire  signed [POSITION_BITS-1:0]  in_east_pos,
  input  wire                              in_sample_valid,
  input  wire                              in_last_sample,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_result_valid,
  output logic [pgd_pkg::PEAK_W-1:0]       out_peak_displacement,
  output logic [pgd_pkg::IDX_W-1:0]        out_reference_index,
  output logic [pgd_pkg::IDX_W-1:0]        out_peak_index,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [pgd_pkg::CFG_AW-1:0]       paddr,
  input  wire  [pgd_pkg::CFG_DW-1:0]       pwdata,
  output logic [pgd_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);
  import pgd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CTL_W = $bits(ctl_t);
  localparam int POS_W = 3 * POSITION_BITS;
  localparam int Q_W   = CTL_W + CNT_W + POS_W;

  // configuration registers
  logic [START_W-1:0] start_r;
  logic [BOUND_W-1:0] end_r, leader_r;
  logic               cfg_wr;
  logic [1:0]         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= END_RESET;
      leader_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_START:  start_r  <= pwdata[START_W-1:0];
        REG_END:    end_r    <= pwdata[BOUND_W-1:0];
        REG_LEADER: leader_r <= pwdata[BOUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_START:  prdata = CFG_DW'(start_r);
      REG_END:    prdata = CFG_DW'(end_r);
      REG_LEADER: prdata = CFG_DW'(leader_r);
      default:    prdata = '0;
    endcase
  end

  // front: sample counting, reference search, classification
  logic               q_push, q_full, q_pop, q_nempty;
  ctl_t               f_ctl, b_ctl;
  logic [CNT_W-1:0]   f_idx, b_idx;
  logic [POS_W-1:0]   f_pos, b_pos;
  logic [Q_W-1:0]     q_rdata;

  pgd_front #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .POSITION_BITS (POSITION_BITS),
    .CNT_W         (CNT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_up_pos       (in_up_pos),
    .in_north_pos    (in_north_pos),
    .in_east_pos     (in_east_pos),
    .in_sample_valid (in_sample_valid),
    .in_last_sample  (in_last_sample),
    .start_index     (start_r),
    .end_index       (end_r),
    .leader_limit    (leader_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ctl           (f_ctl),
    .q_idx           (f_idx),
    .q_pos           (f_pos)
  );

  // command queue decouples the classifier from the multiplier sequence
  pgd_queue #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  ({f_ctl, f_idx, f_pos}),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .rdata  (q_rdata)
  );

  assign b_ctl = ctl_t'(q_rdata[Q_W-1 -: CTL_W]);
  assign b_idx = q_rdata[POS_W +: CNT_W];
  assign b_pos = q_rdata[POS_W-1:0];

  // back: distance, peak tracking, square root and output register
  pgd_back #(
    .POSITION_BITS (POSITION_BITS),
    .CNT_W         (CNT_W)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_nempty              (q_nempty),
    .q_pop                 (q_pop),
    .q_ctl                 (b_ctl),
    .q_idx                 (b_idx),
    .q_pos                 (b_pos),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_valid      (out_result_valid),
    .out_peak_displacement (out_peak_displacement),
    .out_reference_index   (out_reference_index),
    .out_peak_index        (out_peak_index)
  );

endmodule
`default_nettype wire

// ----- bench/pgd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgd_checker
// watches the sample, result and register channels of the peak ground
// displacement tracker, predicts each window result and compares it
// ----------------------------------------------------------------------------
module pgd_checker (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         in_valid,
  input  wire                                         in_stall,
  input  wire signed [pgd_pkg::POSITION_BITS_DEF-1:0] in_up_pos,
  input  wire signed [pgd_pkg::POSITION_BITS_DEF-1:0] in_north_pos,
  input  wire signed [pgd_pkg::POSITION_BITS_DEF-1:0] in_east_pos,
  input  wire                                         in_sample_valid,
  input  wire                                         in_last_sample,
  input  wire                                         out_valid,
  input  wire                                         out_stall,
  input  wire                                         out_result_valid,
  input  wire        [pgd_pkg::PEAK_W-1:0]            out_peak_displacement,
  input  wire        [pgd_pkg::IDX_W-1:0]             out_reference_index,
  input  wire        [pgd_pkg::IDX_W-1:0]             out_peak_index,
  input  wire                                         psel,
  input  wire                                         penable,
  input  wire                                         pwrite,
  input  wire                                         pready,
  input  wire        [pgd_pkg::CFG_AW-1:0]            paddr,
  input  wire        [pgd_pkg::CFG_DW-1:0]            pwdata,
  output int                                          mismatch_count,
  output int                                          peaks_due,
  output int                                          results_seen,
  output int                                          peaks_measured
);
  import pgd_pkg::*;

  localparam int PB = POSITION_BITS_DEF;

  typedef struct packed {
    logic              ok;
    logic [PEAK_W-1:0] disp;
    logic [IDX_W-1:0]  ref_idx;
    logic [IDX_W-1:0]  peak_idx;
  } peak_report_t;

  peak_report_t due_peaks[$];

  // registers as last written
  logic [START_W-1:0] start_at;
  logic [BOUND_W-1:0] end_at;
  logic [BOUND_W-1:0] leader_at;

  // window state
  logic [BOUND_W-1:0]   sample_idx;
  logic                 ref_held;
  logic signed [PB-1:0] ref_up;
  logic signed [PB-1:0] ref_north;
  logic signed [PB-1:0] ref_east;
  logic [IDX_W-1:0]     ref_at;
  logic [63:0]          best_sq;
  logic [IDX_W-1:0]     best_at;

  function automatic logic [63:0] axis_sq(logic signed [PB-1:0] a, logic signed [PB-1:0] b);
    logic signed [PB:0] d;
    logic [PB:0]        mag;
    d   = {a[PB-1], a} - {b[PB-1], b};
    mag = d[PB] ? -d : d;
    return 64'(mag) * 64'(mag);
  endfunction

  function automatic logic [PEAK_W-1:0] floor_root(logic [63:0] x);
    logic [PEAK_W-1:0] r;
    logic [PEAK_W-1:0] trial;
    r = '0;
    for (int b = PEAK_W - 1; b >= 0; b--) begin
      trial = r | (PEAK_W'(1) << b);
      if (64'(trial) * 64'(trial) <= x) r = trial;
    end
    return r;
  endfunction

  function automatic void clear_window();
    sample_idx = '0;
    ref_held   = 1'b0;
    ref_up     = '0;
    ref_north  = '0;
    ref_east   = '0;
    ref_at     = '0;
    best_sq    = '0;
    best_at    = '0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic track_sample(logic signed [PB-1:0] u, logic signed [PB-1:0] n,
                              logic signed [PB-1:0] e, logic ok, logic fin);
    logic [63:0]  d2;
    peak_report_t r;
    if (sample_idx < MAX_SAMPLES_DEF && ok) begin
      if (!ref_held) begin
        if (sample_idx >= start_at && (sample_idx == start_at || sample_idx < leader_at)) begin
          ref_held  = 1'b1;
          ref_up    = u;
          ref_north = n;
          ref_east  = e;
          ref_at    = sample_idx[IDX_W-1:0];
          best_sq   = '0;
          best_at   = sample_idx[IDX_W-1:0];
        end
      end else if (sample_idx < end_at) begin
        d2 = axis_sq(u, ref_up) + axis_sq(n, ref_north) + axis_sq(e, ref_east);
        if (d2 > best_sq) begin
          best_sq = d2;
          best_at = sample_idx[IDX_W-1:0];
        end
      end
    end
    if (sample_idx < MAX_SAMPLES_DEF) sample_idx++;
    if (fin) begin
      r = '0;
      if (ref_held && ref_at < end_at) begin
        r.ok       = 1'b1;
        r.disp     = floor_root(best_sq);
        r.ref_idx  = ref_at;
        r.peak_idx = best_at;
      end
      due_peaks.push_back(r);
      clear_window();
    end
  endtask

  task automatic check_peak();
    peak_report_t want;
    if (due_peaks.size() == 0) begin
      report_mismatch("result with none pending, result_valid", out_result_valid, 0);
      return;
    end
    want = due_peaks.pop_front();
    results_seen++;
    if (want.ok) peaks_measured++;
    if (out_result_valid !== want.ok)
      report_mismatch("result_valid", out_result_valid, want.ok);
    if (out_peak_displacement !== want.disp)
      report_mismatch("peak_displacement", out_peak_displacement, want.disp);
    if (out_reference_index !== want.ref_idx)
      report_mismatch("reference_index", out_reference_index, want.ref_idx);
    if (out_peak_index !== want.peak_idx)
      report_mismatch("peak_index", out_peak_index, want.peak_idx);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_at  = '0;
      end_at    = END_RESET;
      leader_at = '0;
      clear_window();
      due_peaks.delete();
      mismatch_count = 0;
      results_seen   = 0;
      peaks_measured = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_START:  start_at  = pwdata[START_W-1:0];
          REG_END:    end_at    = pwdata[BOUND_W-1:0];
          REG_LEADER: leader_at = pwdata[BOUND_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_peak();
      if (in_valid && !in_stall)
        track_sample(in_up_pos, in_north_pos, in_east_pos, in_sample_valid, in_last_sample);
    end
    peaks_due = due_peaks.size();
  end

endmodule

// ----- bench/peak_ground_displacement_tracker_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_ground_displacement_tracker_tb
// drives windows of three-axis position samples and register settings into
// the tracker under random source gaps and sink stalls; a checker beside the
// block predicts every window result and the verdict comes from its count
// ----------------------------------------------------------------------------
module peak_ground_displacement_tracker_tb;
  import pgd_pkg::*;

  localparam int          PB            = POSITION_BITS_DEF;
  localparam int unsigned RUN_LIMIT     = 400_000;
  // root unit still runs after the last sample, leave margin
  localparam int          SETTLE_CYCLES = 48;
  // least random samples per register setting, twelve random settings in all
  localparam int          SETTING_ITEMS = 30;

  localparam logic [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};
  localparam logic [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};

  typedef enum int {SRC_LIGHT, SRC_HEAVY, NO_IDLE} idle_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  // sample channel
  logic          in_valid        = 1'b0;
  wire           in_stall;
  logic [PB-1:0] in_up_pos       = '0;
  logic [PB-1:0] in_north_pos    = '0;
  logic [PB-1:0] in_east_pos     = '0;
  logic          in_sample_valid = 1'b0;
  logic          in_last_sample  = 1'b0;

  // result channel
  wire               out_valid;
  logic              out_stall = 1'b0;
  wire               out_result_valid;
  wire  [PEAK_W-1:0] out_peak_displacement;
  wire  [IDX_W-1:0]  out_reference_index;
  wire  [IDX_W-1:0]  out_peak_index;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  wire  [CFG_DW-1:0] prdata;
  wire               pready;

  // checker results
  int mismatch_count;
  int peaks_due;
  int results_seen;
  int peaks_measured;

  // run bookkeeping
  int          src_idle_pct   = 12;
  int          sink_stall_pct = 53;
  int          n_samples      = 0;
  int          n_windows      = 0;
  int          n_settings     = 0;
  int unsigned cycle_count    = 0;

  peak_ground_displacement_tracker u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_up_pos             (in_up_pos),
    .in_north_pos          (in_north_pos),
    .in_east_pos           (in_east_pos),
    .in_sample_valid       (in_sample_valid),
    .in_last_sample        (in_last_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_valid      (out_result_valid),
    .out_peak_displacement (out_peak_displacement),
    .out_reference_index   (out_reference_index),
    .out_peak_index        (out_peak_index),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  pgd_checker u_peak_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_up_pos             (in_up_pos),
    .in_north_pos          (in_north_pos),
    .in_east_pos           (in_east_pos),
    .in_sample_valid       (in_sample_valid),
    .in_last_sample        (in_last_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_valid      (out_result_valid),
    .out_peak_displacement (out_peak_displacement),
    .out_reference_index   (out_reference_index),
    .out_peak_index        (out_peak_index),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .pready                (pready),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .mismatch_count        (mismatch_count),
    .peaks_due             (peaks_due),
    .results_seen          (results_seen),
    .peaks_measured        (peaks_measured)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sink back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

  // watchdog against a hung handshake or a lost result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("watchdog: no finish within %0d cycles, %0d results outstanding",
               RUN_LIMIT, peaks_due);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      SRC_LIGHT: begin
        src_idle_pct   = 12;
        sink_stall_pct = 53;
      end
      SRC_HEAVY: begin
        src_idle_pct   = 53;
        sink_stall_pct = 12;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  // one sample transaction; entered and left at a falling edge, and
  // in_valid gets at most one assignment per falling edge
  task automatic drive_sample(logic [PB-1:0] u, logic [PB-1:0] n, logic [PB-1:0] e,
                              logic ok, logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_up_pos       <= u;
    in_north_pos    <= n;
    in_east_pos     <= e;
    in_sample_valid <= ok;
    in_last_sample  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_samples++;
    if (fin) n_windows++;
  endtask

  // hold the source off until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (peaks_due != 0);
  endtask

  // register write: setup cycle then access cycle; random junk above the
  // field width checks that the block keeps only the field bits
  task automatic write_reg(logic [1:0] reg_id, int unsigned value, int width);
    int unsigned junk;
    junk    = $urandom_range(0, 1) ? ($urandom << width) : 0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= (value & ((32'd1 << width) - 1)) | junk;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // new register setting, only once the block has gone quiet
  task automatic apply_settings(int unsigned start_v, int unsigned end_v, int unsigned lead_v);
    drain();
    // a measured sample may still be in flight behind the last result
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_START, start_v, START_W);
    write_reg(REG_END, end_v, BOUND_W);
    write_reg(REG_LEADER, lead_v, BOUND_W);
    n_settings++;
  endtask

  function automatic logic [PB-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // mostly a small step around the window's base point, so that distances
  // stay comparable and ties happen; now and then anything at all
  function automatic logic [PB-1:0] near_coord(logic [PB-1:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return base + PB'($urandom_range(0, 511)) - PB'(256);
      6, 7:             return PB'($urandom);
      8:                return extreme_coord();
      default:          return base ^ (PB'(1) << $urandom_range(0, PB - 1));
    endcase
  endfunction

  // one window of random length; most are well formed (nearly all samples
  // valid), a few are noise with mostly missing samples
  task automatic send_random_window(output int len);
    logic [PB-1:0] bu, bn, be;
    logic [PB-1:0] pu, pn, pe;
    logic [PB-1:0] cu, cn, ce;
    bit            noisy;
    bit            ok;
    int            pick;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    noisy = ($urandom_range(0, 7) == 0);
    bu    = $urandom_range(0, 3) == 0 ? extreme_coord() : PB'($urandom);
    bn    = $urandom_range(0, 3) == 0 ? extreme_coord() : PB'($urandom);
    be    = $urandom_range(0, 3) == 0 ? extreme_coord() : PB'($urandom);
    pu    = bu;
    pn    = bn;
    pe    = be;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 7);
      if (i == 0) begin
        // base point first, so it is often the reference
        cu = bu;
        cn = bn;
        ce = be;
      end else if (pick == 0) begin
        // repeat of the previous point: equal distance, earlier index wins
        cu = pu;
        cn = pn;
        ce = pe;
      end else if (pick == 1) begin
        // previous point mirrored through the base: equal distance again
        cu = bu + bu - pu;
        cn = bn + bn - pn;
        ce = be + be - pe;
      end else begin
        cu = near_coord(bu);
        cn = near_coord(bn);
        ce = near_coord(be);
      end
      ok = noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
      drive_sample(cu, cn, ce, ok, i == len - 1);
      pu = cu;
      pn = cn;
      pe = ce;
    end
  endtask

  initial begin
    int sent;
    int burst;

    // single reset at the start of the run
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idle(SRC_LIGHT);
    n_settings = 1;

    // ---- directed, registers at reset values: start 0, end 4096, leader 0
    // one valid sample that is both reference and last
    drive_sample(PB'(5), PB'(-5), PB'(9), 1'b1, 1'b1);
    // full-scale corner to corner, a repeated peak, a missing sample,
    // then a close valid last sample
    drive_sample(POS_MIN, POS_MIN, POS_MIN, 1'b1, 1'b0);
    drive_sample(POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b0);
    drive_sample(POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b0);
    drive_sample('0, '0, '0, 1'b0, 1'b0);
    drive_sample(PB'(1), PB'(1), PB'(1), 1'b1, 1'b1);
    // nothing valid: no reference
    drive_sample(POS_MAX, '0, POS_MIN, 1'b0, 1'b0);
    drive_sample('1, '1, '1, 1'b0, 1'b0);
    drive_sample(POS_MIN, POS_MAX, '0, 1'b0, 1'b1);
    // start sample missing and no leader allowance: no reference
    drive_sample('0, '0, '0, 1'b0, 1'b0);
    drive_sample(PB'(77), PB'(-3), PB'(12), 1'b1, 1'b1);
    // three points at the same distance from the origin reference
    drive_sample('0, '0, '0, 1'b1, 1'b0);
    drive_sample(PB'(100), PB'(-5), PB'(7), 1'b1, 1'b0);
    drive_sample(PB'(-100), PB'(5), PB'(-7), 1'b1, 1'b0);
    drive_sample(PB'(7), PB'(100), PB'(-5), 1'b1, 1'b0);
    drive_sample('0, '0, PB'(1), 1'b1, 1'b1);

    // ---- directed, start 2, end 3, leader 5
    apply_settings(2, 3, 5);
    // reference found late at index 3, which is not before the end
    drive_sample(PB'(10), PB'(10), PB'(10), 1'b1, 1'b0);
    drive_sample(PB'(20), PB'(20), PB'(20), 1'b1, 1'b0);
    drive_sample(PB'(30), PB'(30), PB'(30), 1'b0, 1'b0);
    drive_sample(PB'(40), PB'(40), PB'(40), 1'b1, 1'b0);
    drive_sample(PB'(-50), PB'(50), PB'(-50), 1'b1, 1'b1);
    // reference at index 2; later samples lie past the end and are not measured
    drive_sample(PB'(10), PB'(10), PB'(10), 1'b1, 1'b0);
    drive_sample(PB'(20), PB'(20), PB'(20), 1'b1, 1'b0);
    drive_sample(PB'(30), PB'(30), PB'(30), 1'b1, 1'b0);
    drive_sample(POS_MAX, POS_MIN, POS_MAX, 1'b1, 1'b0);
    drive_sample(POS_MIN, POS_MAX, POS_MIN, 1'b1, 1'b1);

    // ---- random windows: light source gaps, then heavy, then none;
    // four register settings per idle mode, extremes among them
    for (int m = 0; m < 3; m++) begin
      set_idle(idle_mode_t'(m));
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: apply_settings($urandom_range(0, 4), $urandom_range(1, 14), $urandom_range(0, 10));
          1: apply_settings($urandom_range(0, 3), $urandom_range(0, 1) ? 4096 : 8191,
                            $urandom_range(0, 1) ? 4096 : 8191);
          2: apply_settings($urandom_range(0, 1) ? 0 : 4095,
                            $urandom_range(0, 1) ? 0 : $urandom_range(1, 6), 0);
          default: apply_settings($urandom_range(0, 6), $urandom_range(0, 8191),
                                  $urandom_range(0, 8191));
        endcase
        sent = 0;
        while (sent < SETTING_ITEMS) begin
          // now and then let the pipeline empty completely before a window
          if ($urandom_range(0, 5) == 0) drain();
          send_random_window(burst);
          sent += burst;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d samples in %0d windows under %0d register settings",
             n_samples, n_windows, n_settings);
    $display("run: %0d results compared, %0d carrying a measured peak",
             results_seen, peaks_measured);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pgd_pkg.sv
hdl/pgd_front.sv
hdl/pgd_queue.sv
hdl/pgd_back.sv
hdl/peak_ground_displacement_tracker.sv
bench/pgd_checker.sv
bench/peak_ground_displacement_tracker_tb.sv
